FILE: rtl/core/ordered_value_list_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ordered value list unit
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ORDERED_VALUE_LIST_UNIT_ASSERT_SVH
`define ORDERED_VALUE_LIST_UNIT_ASSERT_SVH

// Same-cycle implication.
`define OVL_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define OVL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/ovl_pkg.sv
// ----------------------------------------------------------------------------
// ovl_pkg
// Command and status codes, field widths and the result record.
// ----------------------------------------------------------------------------
package ovl_pkg;

	localparam int CMD_W    = 2;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 8;
	localparam int STATUS_W = 3;
	localparam int FOUND_W  = 4;
	localparam int COUNT_W  = 5;

	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 16;

	localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;
	localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_POS   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

	typedef struct packed {
		logic [COUNT_W-1:0]  count;
		logic [FOUND_W-1:0]  found;
		logic [STATUS_W-1:0] status;
	} rsp_t;

endpackage

FILE: rtl/core/ovl_store.sv
// ----------------------------------------------------------------------------
// ovl_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ovl_store #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [AW-1:0]                waddr,
	input  logic [ovl_pkg::VALUE_W-1:0]  wdata,
	input  logic                         re,
	input  logic [AW-1:0]                raddr,
	output logic [ovl_pkg::VALUE_W-1:0]  rdata
);
	import ovl_pkg::*;

	logic [VALUE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/ovl_ctrl.sv
// ----------------------------------------------------------------------------
// ovl_ctrl
// Command sequencer: one compare per cycle over the stored entries, then a
// one-entry-per-cycle shift to close the gap after a delete.
// ----------------------------------------------------------------------------
`include "ordered_value_list_unit_assert.svh"

module ovl_ctrl #(
	parameter int CAPACITY = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [ovl_pkg::CMD_W-1:0]            in_cmd,
	input  logic [ovl_pkg::VALUE_W-1:0]          in_value,
	input  logic [ovl_pkg::POS_W-1:0]            in_pos,
	output logic                                 rsp_valid,
	input  logic                                 rsp_ready,
	output ovl_pkg::rsp_t                        rsp,
	output logic                                 mem_we,
	output logic [$clog2(CAPACITY)-1:0]          mem_waddr,
	output logic [ovl_pkg::VALUE_W-1:0]          mem_wdata,
	output logic                                 mem_re,
	output logic [$clog2(CAPACITY)-1:0]          mem_raddr,
	input  logic [ovl_pkg::VALUE_W-1:0]          mem_rdata
);
	import ovl_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > POS_W) ? CW : POS_W;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_SHIFT = 2'd2;
	localparam logic [1:0] S_RESP  = 2'd3;

	logic [1:0]          state_q;
	logic [CW-1:0]       len_q;
	logic [CW-1:0]       rd_idx_q;
	logic                chk_valid_q;
	logic [IW-1:0]       chk_idx_q;
	logic [CMD_W-1:0]    cmd_q;
	logic [VALUE_W-1:0]  value_q;
	logic [STATUS_W-1:0] status_q;
	logic [IW-1:0]       found_q;

	logic          accept;
	logic          full;
	logic          empty;
	logic          pos_lt_len;
	logic          pos_eq_len;
	logic          hit;
	logic          last_chk;
	logic          rd_more;

	assign accept     = in_valid && (state_q == S_IDLE);
	assign in_ready   = (state_q == S_IDLE);
	assign full       = (len_q == CW'(CAPACITY));
	assign empty      = (len_q == '0);
	assign pos_lt_len = (XW'(in_pos) < XW'(len_q));
	assign pos_eq_len = (XW'(in_pos) == XW'(len_q));
	assign hit        = chk_valid_q && (mem_rdata == value_q);
	assign last_chk   = (CW'(chk_idx_q) == (len_q - CW'(1)));
	assign rd_more    = (rd_idx_q < len_q);

	assign mem_re    = ((state_q == S_SCAN) || (state_q == S_SHIFT)) && rd_more;
	assign mem_raddr = rd_idx_q[IW-1:0];

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = len_q[IW-1:0];
		mem_wdata = in_value;
		if (accept) begin
			case (in_cmd)
				CMD_APPEND: begin
					mem_we = !full;
				end
				CMD_UPDATE: begin
					if (!empty && pos_lt_len) begin
						mem_we    = 1'b1;
						mem_waddr = in_pos[IW-1:0];
					end else if (!empty && pos_eq_len) begin
						mem_we = !full;
					end
				end
				default: begin
					mem_we = 1'b0;
				end
			endcase
		end else if ((state_q == S_SHIFT) && chk_valid_q) begin
			// move the entry just read down one place
			mem_we    = 1'b1;
			mem_waddr = chk_idx_q - IW'(1);
			mem_wdata = mem_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= '0;
			rd_idx_q    <= '0;
			chk_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						rd_idx_q    <= '0;
						chk_valid_q <= 1'b0;
						case (in_cmd)
							CMD_APPEND: begin
								if (!full) begin
									len_q <= len_q + CW'(1);
								end
								state_q <= S_RESP;
							end
							CMD_UPDATE: begin
								if (!empty && !pos_lt_len && pos_eq_len && !full) begin
									len_q <= len_q + CW'(1);
								end
								state_q <= S_RESP;
							end
							default: begin
								state_q <= empty ? S_RESP : S_SCAN;
							end
						endcase
					end
				end
				S_SCAN: begin
					rd_idx_q    <= rd_idx_q + CW'(rd_more);
					chk_valid_q <= rd_more;
					if (hit) begin
						state_q <= (cmd_q == CMD_DELETE) ? S_SHIFT : S_RESP;
					end else if (chk_valid_q && last_chk) begin
						state_q <= S_RESP;
					end
				end
				S_SHIFT: begin
					rd_idx_q    <= rd_idx_q + CW'(rd_more);
					chk_valid_q <= rd_more;
					if (!chk_valid_q && !rd_more) begin
						len_q   <= len_q - CW'(1);
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (rsp_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_q   <= in_cmd;
					value_q <= in_value;
					found_q <= '0;
					case (in_cmd)
						CMD_APPEND: begin
							status_q <= full ? ST_FULL : ST_OK;
						end
						CMD_UPDATE: begin
							if (empty) begin
								status_q <= ST_EMPTY;
							end else if (pos_lt_len) begin
								status_q <= ST_OK;
							end else if (pos_eq_len) begin
								status_q <= full ? ST_FULL : ST_OK;
							end else begin
								status_q <= ST_BAD_POS;
							end
						end
						default: begin
							status_q <= empty ? ST_EMPTY : ST_OK;
						end
					endcase
				end
			end
			S_SCAN: begin
				chk_idx_q <= rd_idx_q[IW-1:0];
				if (hit && (cmd_q == CMD_SEARCH)) begin
					found_q <= chk_idx_q;
				end else if (!hit && chk_valid_q && last_chk) begin
					status_q <= ST_NOT_FOUND;
				end
			end
			S_SHIFT: begin
				chk_idx_q <= rd_idx_q[IW-1:0];
			end
			default: begin
				chk_idx_q <= chk_idx_q;
			end
		endcase
	end

	assign rsp_valid  = (state_q == S_RESP);
	assign rsp.status = status_q;
	assign rsp.found  = FOUND_W'(found_q);
	assign rsp.count  = COUNT_W'(len_q);

	`OVL_ASSERT_IMP(a_len_bound, 1'b1, len_q <= CW'(CAPACITY), "entry count above capacity")
	`OVL_ASSERT_NEXT(a_append_grows, accept && (in_cmd == CMD_APPEND) && !full, len_q == $past(len_q) + CW'(1), "append did not grow the count")
	`OVL_ASSERT_IMP(a_shift_nonempty, state_q == S_SHIFT, !empty, "shift on an empty list")
	`OVL_ASSERT_IMP(a_found_in_range, (state_q == S_RESP) && (cmd_q == CMD_SEARCH) && (status_q == ST_OK), CW'(found_q) < len_q, "search hit beyond count")

endmodule

FILE: rtl/core/ordered_value_list_unit.sv
// ----------------------------------------------------------------------------
// ordered_value_list_unit
// Bounded ordered list of signed 32-bit values: append, delete first match,
// search, update at position. One result transaction per command.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tuser: command; s_tdata: value, position
//  m_      | out | m_tvalid/m_tready  | m_tdata: status, found_position, entry_count
//
//  Append and update go from accept straight to the result state.
//  Search makes one compare per stored entry up to the first match, with
//  the registered memory read set in front of each compare.
//  Delete reads on past the match and writes each later entry one place down
//  in the same pass.
//  Reset clears the entry count and the sequencer; no memory clearing pass.
//  A stalled result holds in the output register; the next command is taken
//  while it waits, and its own result waits until that register frees up.
// ----------------------------------------------------------------------------
module ordered_value_list_unit #(
	parameter int CAPACITY = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [31:0] value, [39:32] position
	input  logic [ovl_pkg::IN_TDATA_W-1:0]     s_tdata,
	// [1:0] command
	input  logic [ovl_pkg::CMD_W-1:0]          s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [2:0] status, [6:3] found_position, [11:7] entry_count, [15:12] zero
	output logic [ovl_pkg::OUT_TDATA_W-1:0]    m_tdata
);
	import ovl_pkg::*;

	localparam int IW = $clog2(CAPACITY);

	logic               rsp_valid;
	logic               rsp_ready;
	rsp_t               rsp;
	logic               mem_we;
	logic [IW-1:0]      mem_waddr;
	logic [VALUE_W-1:0] mem_wdata;
	logic               mem_re;
	logic [IW-1:0]      mem_raddr;
	logic [VALUE_W-1:0] mem_rdata;

	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	ovl_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (s_tuser),
		.in_value  (s_tdata[VALUE_W-1:0]),
		.in_pos    (s_tdata[VALUE_W+POS_W-1:VALUE_W]),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	ovl_store #(
		.DEPTH (CAPACITY),
		.AW    (IW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Output register: free when empty or being drained this cycle.
	assign rsp_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (rsp_ready) begin
			m_tvalid_q <= rsp_valid;
		end
	end

	// Load the result record; hold it while the consumer stalls.
	always_ff @(posedge clk) begin
		if (rsp_ready && rsp_valid) begin
			m_tdata_q <= OUT_TDATA_W'(rsp);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

FILE: sim/tb_ordered_value_list_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_value_list_unit
// Self-checking bench for the ordered value list unit. A local model of the
// list predicts status, match position and entry count for each command.
// The commands run through directed edge cases, fill to capacity, random
// traffic with idle gaps, back-to-back bursts and a long output stall.
// ----------------------------------------------------------------------------
module tb_ordered_value_list_unit;

	import ovl_pkg::*;

	localparam int CAPACITY           = 16;
	localparam int STALL_LIMIT        = 2000;   // cycles with no transaction on either side
	localparam int OUTPUT_HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES      = 2 * CAPACITY + 8;

	localparam logic [VALUE_W-1:0] VAL_MIN  = 32'h8000_0000;
	localparam logic [VALUE_W-1:0] VAL_MAX  = 32'h7FFF_FFFF;
	localparam logic [VALUE_W-1:0] VAL_ONES = 32'hFFFF_FFFF;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;    // [31:0] value, [39:32] position
	logic [CMD_W-1:0]       s_tuser;    // [1:0] command
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;    // [2:0] status, [6:3] found_position,
	                                    // [11:7] entry_count, [15:12] zero

	// Local copy of the list contents and length.
	logic [VALUE_W-1:0] list_mem [CAPACITY];
	int                 list_len;

	rsp_t expected_rsp_q [$];

	int  error_count;
	int  cmd_seen [4];
	int  status_seen [8];
	bit  no_idle_in;
	bit  no_idle_out;
	int  long_hold_cycles;

	ordered_value_list_unit #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// List model
	// ------------------------------------------------------------------------
	function automatic logic [STATUS_W-1:0] append_entry(input logic [VALUE_W-1:0] value);
		if (list_len >= CAPACITY)
			return ST_FULL;
		list_mem[list_len] = value;
		list_len++;
		return ST_OK;
	endfunction

	// Apply one command to the local list and return the result it must give.
	function automatic rsp_t predict_list_op(input logic [CMD_W-1:0] cmd,
			input logic [VALUE_W-1:0] value, input logic [POS_W-1:0] pos);
		rsp_t r;
		int   at;
		bit   hit;
		int   i;
		r.status = ST_OK;
		r.found  = '0;
		at       = 0;
		hit      = 1'b0;
		// first match, full 32-bit compare
		for (i = 0; i < list_len && !hit; i++) begin
			if (list_mem[i] == value) begin
				at  = i;
				hit = 1'b1;
			end
		end
		case (cmd)
			CMD_APPEND: r.status = append_entry(value);
			CMD_DELETE: begin
				if (list_len == 0)
					r.status = ST_EMPTY;
				else if (hit) begin
					for (i = at; i < list_len - 1; i++)
						list_mem[i] = list_mem[i + 1];
					list_len--;
				end else
					r.status = ST_NOT_FOUND;
			end
			CMD_SEARCH: begin
				if (list_len == 0)
					r.status = ST_EMPTY;
				else if (hit)
					r.found = FOUND_W'(at);
				else
					r.status = ST_NOT_FOUND;
			end
			CMD_UPDATE: begin
				if (list_len == 0)
					r.status = ST_EMPTY;
				else if (pos < list_len)
					list_mem[pos] = value;
				else if (pos == list_len)
					r.status = append_entry(value);
				else
					r.status = ST_BAD_POS;
			end
		endcase
		r.count = COUNT_W'(list_len);
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------------
	// Offer one command after a random gap; return at the accepting edge.
	task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value,
			input logic [POS_W-1:0] pos);
		int gap;
		gap = no_idle_in ? 0 : $urandom_range(0, 10);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {pos, value};
		s_tuser  <= cmd;
		do @(posedge clk); while (!s_tready);
		expected_rsp_q.push_back(predict_list_op(cmd, value, pos));
		cmd_seen[cmd]++;
	endtask

	// Drop valid and hold until every outstanding result is back.
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_rsp_q.size() != 0) @(posedge clk);
	endtask

	// Mostly values already in the list or from a small pool, so searches
	// and deletes hit and duplicates form; the rest are corners and noise.
	function automatic logic [VALUE_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 9);
		if (list_len != 0 && r < 5)
			return list_mem[$urandom_range(0, list_len - 1)];
		if (r < 7)
			return VALUE_W'($urandom_range(0, 7));
		if (r == 7) begin
			case ($urandom_range(0, 3))
				0: return VAL_MIN;
				1: return VAL_MAX;
				2: return VAL_ONES;
				default: return '0;
			endcase
		end
		return $urandom;
	endfunction

	function automatic logic [POS_W-1:0] pick_position();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return POS_W'($urandom_range(0, list_len));
		if (r == 7)
			return POS_W'(list_len + 1);
		return POS_W'($urandom_range(0, 255));
	endfunction

	// Weight commands by fill level so the length sweeps the whole range.
	task automatic run_random_commands(input int n);
		int                 r;
		logic [CMD_W-1:0]   cmd;
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (list_len >= CAPACITY - 3)
				cmd = (r < 15) ? CMD_APPEND : (r < 50) ? CMD_DELETE :
				      (r < 75) ? CMD_SEARCH : CMD_UPDATE;
			else if (list_len <= 3)
				cmd = (r < 45) ? CMD_APPEND : (r < 60) ? CMD_DELETE :
				      (r < 80) ? CMD_SEARCH : CMD_UPDATE;
			else
				cmd = (r < 30) ? CMD_APPEND : (r < 55) ? CMD_DELETE :
				      (r < 80) ? CMD_SEARCH : CMD_UPDATE;
			send_item(cmd, pick_value(), pick_position());
		end
	endtask

	// ------------------------------------------------------------------------
	// Output side
	// ------------------------------------------------------------------------
	initial begin : result_sink
		int stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (long_hold_cycles > 0) begin
				stall = long_hold_cycles;
				long_hold_cycles = 0;
			end else if (no_idle_out)
				stall = 0;
			else
				stall = $urandom_range(0, 10);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin : result_check
		rsp_t want;
		rsp_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[$bits(rsp_t)-1:0];
			if (expected_rsp_q.size() == 0) begin
				$error("result transaction with nothing outstanding: m_tdata=%h", m_tdata);
				error_count++;
			end else begin
				want = expected_rsp_q.pop_front();
				status_seen[got.status]++;
				if (got.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, got.status);
					error_count++;
				end
				if (got.found !== want.found) begin
					$error("found_position: expected %0d, got %0d", want.found, got.found);
					error_count++;
				end
				if (got.count !== want.count) begin
					$error("entry_count: expected %0d, got %0d", want.count, got.count);
					error_count++;
				end
				if (m_tdata[OUT_TDATA_W-1:$bits(rsp_t)] !== '0) begin
					$error("padding: expected 0, got %h", m_tdata[OUT_TDATA_W-1:$bits(rsp_t)]);
					error_count++;
				end
			end
		end
	end

	// End the run if the handshakes stop moving.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no transaction for %0d cycles", STALL_LIMIT);
		$display("FAILURE");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	// Update, delete and search against a list that holds nothing.
	task automatic test_empty_list();
		send_item(CMD_UPDATE, VAL_MAX, 8'd255);
		send_item(CMD_UPDATE, VAL_MIN, 8'd0);
		send_item(CMD_DELETE, VAL_MIN, 8'd0);
		send_item(CMD_SEARCH, '0, 8'd0);
		drain_results();
	endtask

	// Head replace, update-append, bad positions, first match among duplicates,
	// near misses and gap closing in the middle.
	task automatic test_edits_and_lookups();
		send_item(CMD_APPEND, VAL_MIN, 8'd0);
		send_item(CMD_UPDATE, VAL_MAX, 8'd1);
		send_item(CMD_UPDATE, VAL_ONES, 8'd0);
		send_item(CMD_APPEND, '0, 8'd0);
		send_item(CMD_APPEND, VAL_MAX, 8'd0);
		send_item(CMD_SEARCH, VAL_MAX, 8'd0);
		send_item(CMD_SEARCH, 32'h7FFF_FFFE, 8'd0);
		send_item(CMD_SEARCH, VAL_ONES, 8'd0);
		send_item(CMD_UPDATE, 32'hAAAA_AAAA, 8'd5);
		send_item(CMD_UPDATE, 32'hAAAA_AAAA, 8'd255);
		send_item(CMD_UPDATE, 32'h5555_5555, 8'd4);
		send_item(CMD_DELETE, '0, 8'd0);
		send_item(CMD_DELETE, 32'h1234_5678, 8'd0);
		send_item(CMD_SEARCH, 32'h5555_5555, 8'd0);
		send_item(CMD_DELETE, VAL_MAX, 8'd0);
		send_item(CMD_SEARCH, VAL_MAX, 8'd0);
		drain_results();
	endtask

	// Fill to capacity, probe the full list, then delete it down to nothing.
	task automatic test_fill_to_capacity();
		while (list_len < CAPACITY)
			send_item(CMD_APPEND, $urandom, POS_W'($urandom_range(0, 255)));
		send_item(CMD_APPEND, $urandom, 8'd0);
		send_item(CMD_UPDATE, $urandom, POS_W'(CAPACITY));
		send_item(CMD_UPDATE, $urandom, POS_W'(CAPACITY - 1));
		send_item(CMD_SEARCH, list_mem[CAPACITY - 1], 8'd0);
		send_item(CMD_DELETE, list_mem[0], 8'd0);
		send_item(CMD_UPDATE, $urandom, POS_W'(CAPACITY - 1));
		send_item(CMD_SEARCH, list_mem[CAPACITY - 1], 8'd0);
		while (list_len != 0)
			send_item(CMD_DELETE, list_mem[$urandom_range(0, list_len - 1)],
			          POS_W'($urandom_range(0, 255)));
		drain_results();
	endtask

	task automatic test_random_traffic(input int n);
		run_random_commands(n);
		drain_results();
	endtask

	// No idling on either side.
	task automatic test_back_to_back(input int n);
		no_idle_in  = 1'b1;
		no_idle_out = 1'b1;
		run_random_commands(n);
		drain_results();
		no_idle_in  = 1'b0;
		no_idle_out = 1'b0;
	endtask

	// Stall the output for a long stretch while commands keep coming, so the
	// unit fills and holds off its input.
	task automatic test_output_hold(input int n);
		no_idle_in       = 1'b1;
		long_hold_cycles = OUTPUT_HOLD_CYCLES;
		run_random_commands(n);
		drain_results();
		no_idle_in = 1'b0;
	endtask

	initial begin
		s_tvalid         = 1'b0;
		s_tdata          = '0;
		s_tuser          = '0;
		arst_n           = 1'b0;
		list_len         = 0;
		error_count      = 0;
		no_idle_in       = 1'b0;
		no_idle_out      = 1'b0;
		long_hold_cycles = 0;
		cmd_seen         = '{default: 0};
		status_seen      = '{default: 0};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_list();
		test_edits_and_lookups();
		test_fill_to_capacity();
		test_random_traffic(900);
		test_back_to_back(200);
		test_output_hold(40);

		// catch any stray result
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Ran %0d append, %0d delete, %0d search, %0d update commands with gaps, bursts",
		         cmd_seen[CMD_APPEND], cmd_seen[CMD_DELETE], cmd_seen[CMD_SEARCH],
		         cmd_seen[CMD_UPDATE]);
		$display("and a %0d-cycle output stall; statuses ok %0d, empty %0d, not found %0d, bad position %0d, full %0d",
		         OUTPUT_HOLD_CYCLES, status_seen[ST_OK], status_seen[ST_EMPTY],
		         status_seen[ST_NOT_FOUND], status_seen[ST_BAD_POS], status_seen[ST_FULL]);
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
